// ===== design/prba_pkg.sv =====
`default_nettype none

package prba_pkg;

   // segment geometry
   localparam int SEGMENT_PAGES = 128;
   localparam int PAGE_W        = $clog2(SEGMENT_PAGES);
   localparam int COUNT_W       = 8;
   localparam int ALREADY_W     = 7;
   localparam int LIMIT_W       = 16;
   localparam int MAX_RUN       = SEGMENT_PAGES / 2;

   // free page recount works through the map a chunk at a time
   localparam int CHUNK_W       = 8;
   localparam int CHUNKS        = SEGMENT_PAGES / CHUNK_W;
   localparam int CHUNK_IDX_W   = $clog2(CHUNKS);
   localparam int POP_W         = $clog2(CHUNK_W + 1);

   // register reset values
   localparam logic [PAGE_W-1:0]  HEADER_RESET = PAGE_W'(1);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(64);
   localparam logic [COUNT_W-1:0] FREE_RESET   = COUNT_W'(SEGMENT_PAGES - 1);

   typedef enum logic [0:0] {
      CSR_HEADER_PAGES = 1'b0,
      CSR_CACHE_LIMIT  = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_STATUS   = 2'd0,
      KIND_COMMIT   = 2'd1,
      KIND_DECOMMIT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_SIZE = 2'd1,
      ST_NO_ROOM  = 2'd2,
      ST_BAD_FREE = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== design/page_run_bitmap_allocator.sv =====
// allocate: a first-fit search over up to the whole segment, then two walks over the
//   run (tally, then mark and commit), then the free page recount, chunk by chunk
// free: a lookup of the run, a status beat and an optional decommit beat, then a walk
//   over the run to release it, then the recount; an error status is a single beat
// throughput: one beat at a time, req_stall high until the item and any recount are done
// reset: synchronous; maps cleared, no runs, header_pages 1, commit_cache_limit 64
`default_nettype none

module page_run_bitmap_allocator
   import prba_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_action,
   input  wire logic [COUNT_W-1:0]   req_page_count,
   input  wire logic [PAGE_W-1:0]    req_first_page,

   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [1:0]                rsp_status,
   output logic [PAGE_W-1:0]         rsp_page,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic [ALREADY_W-1:0]      rsp_already_committed,
   output logic                      rsp_last,

   // register write port
   input  wire logic                 csr_write,
   input  wire logic [0:0]           csr_index,
   input  wire logic [LIMIT_W-1:0]   csr_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_REPORT,       // single error status beat
      S_SEARCH,       // first-fit walk over the busy map
      S_TALLY,        // count pages of the run already committed
      S_ALLOC_STATUS,
      S_MARK,         // mark busy, commit and emit commit runs
      S_MARK_TAIL,    // commit run that reaches the end of the allocation
      S_FREE_READ,
      S_FREE_STATUS,
      S_DECOMMIT,
      S_FREE_WALK,
      S_RECOUNT
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [PAGE_W-1:0]  header_ff, header_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   // segment state
   logic [SEGMENT_PAGES-1:0] busy_ff, busy_in;
   logic [SEGMENT_PAGES-1:0] commit_ff, commit_in;
   logic [SEGMENT_PAGES-1:0] run_valid_ff, run_valid_in;
   logic [COUNT_W-1:0]       free_count_ff, free_count_in;
   logic [COUNT_W-1:0]       cfc_ff, cfc_in;

   // per item working registers
   logic [COUNT_W-1:0]   want_ff, want_in;       // run length of the item
   logic [PAGE_W-1:0]    page_ff, page_in;       // first page of the run
   logic [PAGE_W-1:0]    pos_ff, pos_in;         // walking page pointer
   logic [PAGE_W-1:0]    run_ff, run_in;
   logic [COUNT_W-1:0]   end_ff, end_in;         // one past the last page of the run
   logic [ALREADY_W-1:0] already_ff, already_in;
   logic [ALREADY_W-1:0] seen_ff, seen_in;       // uncommitted pages passed so far
   logic [PAGE_W-1:0]    start_ff, start_in;
   logic                 open_ff, open_in;
   logic                 decommit_ff, decommit_in;
   status_type           err_ff, err_in;
   logic [CHUNK_IDX_W-1:0] chunk_ff, chunk_in;
   logic [COUNT_W-1:0]     acc_ff, acc_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]    rsp_page_ff, rsp_page_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [ALREADY_W-1:0] rsp_already_ff, rsp_already_in;
   logic                 rsp_last_ff, rsp_last_in;

   // run length table
   logic               ram_we;
   logic [PAGE_W-1:0]  ram_rd_addr;
   logic [COUNT_W-1:0] ram_rd_data;

   prba_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (SEGMENT_PAGES)
   ) u_run_len (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (page_ff),
      .wr_data (want_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // a write of header_pages while idle or recounting (re)starts the free page recount
   logic hdr_write;
   assign hdr_write = csr_write && (csr_index == CSR_HEADER_PAGES);

   assign req_stall = (state_ff != S_IDLE) || hdr_write;
   assign ram_rd_addr = (state_ff == S_IDLE) ? req_first_page : page_ff;

   // the shared page probe: status of the page under the walking pointer
   logic pos_hdr, pos_busy, pos_committed;
   assign pos_hdr       = pos_ff < header_ff;
   assign pos_busy      = pos_hdr || busy_ff[pos_ff];
   assign pos_committed = pos_hdr || commit_ff[pos_ff];

   logic [COUNT_W-1:0] pos_next;
   logic               pos_at_end;
   assign pos_next   = {1'b0, pos_ff} + COUNT_W'(1);
   assign pos_at_end = pos_next == end_ff;

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // free pages in the chunk under recount
   logic [SEGMENT_PAGES-1:0] free_vec;
   logic [CHUNK_W-1:0]       chunk_bits;
   logic [POP_W-1:0]         chunk_pop;

   always_comb begin
      for (int i = 0; i < SEGMENT_PAGES; i++) begin
         free_vec[i] = !busy_ff[i] && !(PAGE_W'(i) < header_ff);
      end
      chunk_bits = free_vec[int'(chunk_ff) * CHUNK_W +: CHUNK_W];
      chunk_pop  = '0;
      for (int j = 0; j < CHUNK_W; j++) begin
         chunk_pop = chunk_pop + POP_W'(chunk_bits[j]);
      end
   end

   // free run lookup
   logic [COUNT_W:0]   free_end_raw;
   logic [COUNT_W-1:0] free_end;
   logic [COUNT_W-1:0] free_len;
   logic [COUNT_W:0]   cfc_plus;
   assign free_end_raw = {2'b00, page_ff} + {1'b0, ram_rd_data};
   assign free_end     = (free_end_raw > (COUNT_W+1)'(SEGMENT_PAGES)) ?
                         COUNT_W'(SEGMENT_PAGES) : free_end_raw[COUNT_W-1:0];
   assign free_len     = free_end - {1'b0, page_ff};
   assign cfc_plus     = {1'b0, cfc_ff} + {1'b0, want_ff};

   logic               emit;
   kind_type           e_kind;
   status_type         e_status;
   logic [PAGE_W-1:0]  e_page;
   logic [COUNT_W-1:0] e_count;
   logic [ALREADY_W-1:0] e_already;
   logic               e_last;
   logic [COUNT_W-1:0] uncommitted;
   logic [PAGE_W:0]    first_calc;
   logic [COUNT_W:0]   ext_sum;

   assign uncommitted = want_ff - {1'b0, already_ff};

   always_comb begin
      state_in       = state_ff;
      header_in      = header_ff;
      limit_in       = limit_ff;
      busy_in        = busy_ff;
      commit_in      = commit_ff;
      run_valid_in   = run_valid_ff;
      free_count_in  = free_count_ff;
      cfc_in         = cfc_ff;
      want_in        = want_ff;
      page_in        = page_ff;
      pos_in         = pos_ff;
      run_in         = run_ff;
      end_in         = end_ff;
      already_in     = already_ff;
      seen_in        = seen_ff;
      start_in       = start_ff;
      open_in        = open_ff;
      decommit_in    = decommit_ff;
      err_in         = err_ff;
      chunk_in       = chunk_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_page_in    = rsp_page_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_already_in = rsp_already_ff;
      rsp_last_in    = rsp_last_ff;
      emit           = 1'b0;
      e_kind         = KIND_STATUS;
      e_status       = ST_OK;
      e_page         = '0;
      e_count        = '0;
      e_already      = '0;
      e_last         = 1'b0;
      ram_we         = 1'b0;
      first_calc     = '0;
      ext_sum        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               want_in = req_page_count;
               page_in = req_first_page;
               if (req_action == ACT_FREE) begin
                  state_in = S_FREE_READ;
               end else if (req_page_count == '0 ||
                            req_page_count > COUNT_W'(MAX_RUN)) begin
                  err_in   = ST_BAD_SIZE;
                  page_in  = '0;
                  state_in = S_REPORT;
               end else if (free_count_ff < req_page_count) begin
                  err_in   = ST_NO_ROOM;
                  page_in  = '0;
                  state_in = S_REPORT;
               end else begin
                  pos_in   = '0;
                  run_in   = '0;
                  state_in = S_SEARCH;
               end
            end
         end

         S_REPORT: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = err_ff;
               e_page   = page_ff;
               e_last   = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_SEARCH: begin
            if (pos_busy) begin
               run_in = '0;
            end else begin
               run_in = run_ff + PAGE_W'(1);
            end
            if (!pos_busy && ({1'b0, run_ff} + COUNT_W'(1)) == want_ff) begin
               // run found, it ends at the current page
               first_calc = (PAGE_W+1)'(pos_next - want_ff);
               page_in    = first_calc[PAGE_W-1:0];
               pos_in     = first_calc[PAGE_W-1:0];
               end_in     = pos_next;
               already_in = '0;
               state_in   = S_TALLY;
            end else if (pos_ff == PAGE_W'(SEGMENT_PAGES - 1)) begin
               err_in   = ST_NO_ROOM;
               page_in  = '0;
               state_in = S_REPORT;
            end else begin
               pos_in = pos_next[PAGE_W-1:0];
            end
         end

         S_TALLY: begin
            if (pos_committed) begin
               already_in = already_ff + ALREADY_W'(1);
            end
            if (pos_at_end) begin
               state_in = S_ALLOC_STATUS;
            end else begin
               pos_in = pos_next[PAGE_W-1:0];
            end
         end

         S_ALLOC_STATUS: begin
            if (out_free) begin
               emit      = 1'b1;
               e_page    = page_ff;
               e_count   = want_ff;
               e_already = already_ff;
               e_last    = {1'b0, already_ff} == want_ff;
               ram_we    = 1'b1;
               run_valid_in[page_ff] = 1'b1;
               cfc_in    = (cfc_ff > {1'b0, already_ff}) ?
                           cfc_ff - {1'b0, already_ff} : '0;
               pos_in    = page_ff;
               seen_in   = '0;
               open_in   = 1'b0;
               state_in  = S_MARK;
            end
         end

         S_MARK: begin
            if (pos_committed) begin
               // a committed page closes an open commit run
               if (!open_ff || out_free) begin
                  if (open_ff) begin
                     emit    = 1'b1;
                     e_kind  = KIND_COMMIT;
                     e_page  = start_ff;
                     e_count = {1'b0, pos_ff} - {1'b0, start_ff};
                     e_last  = {1'b0, seen_ff} == uncommitted;
                  end
                  busy_in[pos_ff] = 1'b1;
                  open_in = 1'b0;
                  if (pos_at_end) begin
                     chunk_in = '0;
                     acc_in   = '0;
                     state_in = S_RECOUNT;
                  end else begin
                     pos_in = pos_next[PAGE_W-1:0];
                  end
               end
            end else begin
               busy_in[pos_ff]   = 1'b1;
               commit_in[pos_ff] = 1'b1;
               seen_in = seen_ff + ALREADY_W'(1);
               if (!open_ff) begin
                  start_in = pos_ff;
               end
               open_in = 1'b1;
               if (pos_at_end) begin
                  state_in = S_MARK_TAIL;
               end else begin
                  pos_in = pos_next[PAGE_W-1:0];
               end
            end
         end

         S_MARK_TAIL: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = KIND_COMMIT;
               e_page   = start_ff;
               e_count  = end_ff - {1'b0, start_ff};
               e_last   = 1'b1;
               open_in  = 1'b0;
               chunk_in = '0;
               acc_in   = '0;
               state_in = S_RECOUNT;
            end
         end

         S_FREE_READ: begin
            if (!run_valid_ff[page_ff]) begin
               err_in   = ST_BAD_FREE;
               state_in = S_REPORT;
            end else begin
               want_in  = free_len;
               end_in   = free_end;
               pos_in   = page_ff;
               state_in = S_FREE_STATUS;
            end
         end

         S_FREE_STATUS: begin
            decommit_in = (LIMIT_W'(cfc_plus)) > limit_ff;
            if (out_free) begin
               emit    = 1'b1;
               e_page  = page_ff;
               e_count = want_ff;
               e_last  = !decommit_in;
               if (decommit_in) begin
                  state_in = S_DECOMMIT;
               end else begin
                  ext_sum  = cfc_plus;
                  cfc_in   = ext_sum[COUNT_W] ? '1 : ext_sum[COUNT_W-1:0];
                  state_in = S_FREE_WALK;
               end
            end
         end

         S_DECOMMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = KIND_DECOMMIT;
               e_page   = page_ff;
               e_count  = want_ff;
               e_last   = 1'b1;
               state_in = S_FREE_WALK;
            end
         end

         S_FREE_WALK: begin
            busy_in[pos_ff] = 1'b0;
            if (decommit_ff) begin
               commit_in[pos_ff] = 1'b0;
            end
            run_valid_in[page_ff] = 1'b0;
            if (pos_at_end) begin
               chunk_in = '0;
               acc_in   = '0;
               state_in = S_RECOUNT;
            end else begin
               pos_in = pos_next[PAGE_W-1:0];
            end
         end

         S_RECOUNT: begin
            acc_in = acc_ff + COUNT_W'(chunk_pop);
            if (chunk_ff == CHUNK_IDX_W'(CHUNKS - 1)) begin
               free_count_in = acc_ff + COUNT_W'(chunk_pop);
               state_in      = S_IDLE;
            end else begin
               chunk_in = chunk_ff + CHUNK_IDX_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes
      if (csr_write) begin
         case (csr_index)
            CSR_HEADER_PAGES: header_in = csr_data[PAGE_W-1:0];
            CSR_CACHE_LIMIT:  limit_in  = csr_data;
            default: ;
         endcase
      end
      // new header count, start or restart the free page recount
      if (hdr_write && (state_ff == S_IDLE || state_ff == S_RECOUNT)) begin
         chunk_in = '0;
         acc_in   = '0;
         state_in = S_RECOUNT;
      end

      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = e_kind;
         rsp_status_in  = e_status;
         rsp_page_in    = e_page;
         rsp_count_in   = e_count;
         rsp_already_in = e_already;
         rsp_last_in    = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         header_ff     <= HEADER_RESET;
         limit_ff      <= LIMIT_RESET;
         busy_ff       <= '0;
         commit_ff     <= '0;
         run_valid_ff  <= '0;
         free_count_ff <= FREE_RESET;
         cfc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         header_ff     <= header_in;
         limit_ff      <= limit_in;
         busy_ff       <= busy_in;
         commit_ff     <= commit_in;
         run_valid_ff  <= run_valid_in;
         free_count_ff <= free_count_in;
         cfc_ff        <= cfc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      want_ff        <= want_in;
      page_ff        <= page_in;
      pos_ff         <= pos_in;
      run_ff         <= run_in;
      end_ff         <= end_in;
      already_ff     <= already_in;
      seen_ff        <= seen_in;
      start_ff       <= start_in;
      open_ff        <= open_in;
      decommit_ff    <= decommit_in;
      err_ff         <= err_in;
      chunk_ff       <= chunk_in;
      acc_ff         <= acc_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_page_ff    <= rsp_page_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_already_ff <= rsp_already_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_page              = rsp_page_ff;
   assign rsp_count             = rsp_count_ff;
   assign rsp_already_committed = rsp_already_ff;
   assign rsp_last              = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/prba_ram.sv =====
`default_nettype none

module prba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== bench/page_run_bitmap_allocator_tb.sv =====
module page_run_bitmap_allocator_tb
   import prba_pkg::*;
;

   // quiet cycles allowed before the run is called hung: room for a full search, two
   // walks of the largest run and the recount, plus the settle pause
   localparam int QUIET_LIMIT   = 4000;
   // pause after the last result before touching registers or ending the run,
   // long enough to cover the trailing free page recount with room to spare
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      kind_type               kind;
      status_type             status;
      logic [PAGE_W-1:0]      page;
      logic [COUNT_W-1:0]     count;
      logic [ALREADY_W-1:0]   already;
      logic                   last;
   } page_result_type;

   // clock, reset and every block input start at a known value
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_action     = 1'b0;
   logic [COUNT_W-1:0]     req_page_count = '0;
   logic [PAGE_W-1:0]      req_first_page = '0;
   logic                   rsp_stall      = 1'b0;
   logic                   csr_write      = 1'b0;
   logic [0:0]             csr_index      = '0;
   logic [LIMIT_W-1:0]     csr_data       = '0;

   logic                   req_stall;
   logic                   rsp_valid;
   logic [1:0]             rsp_kind;
   logic [1:0]             rsp_status;
   logic [PAGE_W-1:0]      rsp_page;
   logic [COUNT_W-1:0]     rsp_count;
   logic [ALREADY_W-1:0]   rsp_already_committed;
   logic                   rsp_last;

   // shadow of the segment, kept in step with every accepted beat
   logic [SEGMENT_PAGES-1:0] busy_pages;
   logic [SEGMENT_PAGES-1:0] committed_pages;
   logic [COUNT_W-1:0]       run_len [SEGMENT_PAGES];
   int                       free_pages;
   int                       cached_free;
   int                       header_count;
   int                       cache_limit;

   // results of the beat being predicted, then the ones still owed by the block
   page_result_type          staged[$];
   page_result_type          awaited_results[$];

   int                       mismatches    = 0;
   int                       quiet_cycles  = 0;
   int                       send_idle_pct = 36;
   int                       recv_idle_pct = 79;

   page_run_bitmap_allocator u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_page_count        (req_page_count),
      .req_first_page        (req_first_page),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_kind              (rsp_kind),
      .rsp_status            (rsp_status),
      .rsp_page              (rsp_page),
      .rsp_count             (rsp_count),
      .rsp_already_committed (rsp_already_committed),
      .rsp_last              (rsp_last),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // header pages always count as taken and backed, whatever the maps say
   function automatic bit page_taken(int p);
      return p < header_count || busy_pages[p];
   endfunction

   function automatic bit page_backed(int p);
      return p < header_count || committed_pages[p];
   endfunction

   function automatic void recount_free_pages();
      int p;
      free_pages = 0;
      for (p = 0; p < SEGMENT_PAGES; p++)
         if (!page_taken(p))
            free_pages++;
   endfunction

   function automatic page_result_type run_request(kind_type k, int start, int len);
      page_result_type r;
      r       = '0;
      r.kind  = k;
      r.page  = PAGE_W'(start);
      r.count = COUNT_W'(len);
      return r;
   endfunction

   function automatic void reset_segment();
      int p;
      busy_pages      = '0;
      committed_pages = '0;
      for (p = 0; p < SEGMENT_PAGES; p++)
         run_len[p] = '0;
      header_count = HEADER_RESET;
      cache_limit  = LIMIT_RESET;
      cached_free  = 0;
      recount_free_pages();
   endfunction

   // first fit search, then one commit request per stretch not yet backed
   function automatic void predict_alloc(int want);
      int              p;
      int              run;
      int              first;
      int              already;
      int              start;
      bit              found;
      bit              open;
      page_result_type head;
      page_result_type commits[$];
      head      = '0;
      head.kind = KIND_STATUS;
      run       = 0;
      first     = 0;
      already   = 0;
      start     = 0;
      found     = 1'b0;
      open      = 1'b0;
      if (want == 0 || want > MAX_RUN) begin
         head.status = ST_BAD_SIZE;
      end else if (free_pages < want) begin
         head.status = ST_NO_ROOM;
      end else begin
         for (p = 0; p < SEGMENT_PAGES && !found; p++) begin
            if (page_taken(p)) begin
               run = 0;
            end else begin
               run++;
               if (run == want) begin
                  first = p + 1 - want;
                  found = 1'b1;
               end
            end
         end
         if (!found) begin
            head.status = ST_NO_ROOM;
         end else begin
            for (p = first; p < first + want; p++) begin
               busy_pages[p] = 1'b1;
               if (page_backed(p)) begin
                  already++;
                  if (open) begin
                     commits.push_back(run_request(KIND_COMMIT, start, p - start));
                     open = 1'b0;
                  end
               end else begin
                  committed_pages[p] = 1'b1;
                  if (!open) begin
                     start = p;
                     open  = 1'b1;
                  end
               end
            end
            if (open)
               commits.push_back(run_request(KIND_COMMIT, start, first + want - start));
            run_len[first] = COUNT_W'(want);
            cached_free    = (cached_free > already) ? cached_free - already : 0;
            recount_free_pages();
            head.status  = ST_OK;
            head.page    = PAGE_W'(first);
            head.count   = COUNT_W'(want);
            head.already = ALREADY_W'(already);
         end
      end
      staged.push_back(head);
      foreach (commits[i])
         staged.push_back(commits[i]);
   endfunction

   // release a run; decommit it when the cache of backed free pages would overflow
   function automatic void predict_free(int fp);
      int              p;
      int              len;
      page_result_type head;
      head      = '0;
      head.kind = KIND_STATUS;
      head.page = PAGE_W'(fp);
      if (run_len[fp] == 0) begin
         head.status = ST_BAD_FREE;
         staged.push_back(head);
      end else begin
         len = run_len[fp];
         if (fp + len > SEGMENT_PAGES)
            len = SEGMENT_PAGES - fp;
         head.status = ST_OK;
         head.count  = COUNT_W'(len);
         staged.push_back(head);
         if (cached_free + len > cache_limit) begin
            for (p = fp; p < fp + len; p++)
               committed_pages[p] = 1'b0;
            staged.push_back(run_request(KIND_DECOMMIT, fp, len));
         end else begin
            cached_free = (cached_free + len > 255) ? 255 : cached_free + len;
         end
         for (p = fp; p < fp + len; p++)
            busy_pages[p] = 1'b0;
         run_len[fp] = '0;
         recount_free_pages();
      end
   endfunction

   // ---------------------------------------------------------------- driving

   // one request beat; optional hold-off until the block has answered everything
   task automatic send_beat(action_type act, int cnt, int fp, bit hold);
      page_result_type r;
      if (hold) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (awaited_results.size() != 0);
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_page_count <= COUNT_W'(cnt);
      req_first_page <= PAGE_W'(fp);
      do @(posedge clock); while (req_stall);
      // beat taken at this edge: work out what it owes
      staged = {};
      if (act == ACT_ALLOC)
         predict_alloc(cnt);
      else
         predict_free(fp);
      foreach (staged[i]) begin
         r      = staged[i];
         r.last = (i == staged.size() - 1);
         awaited_results.push_back(r);
      end
   endtask

   // block idle: no beat offered, every result in, trailing recount over
   task automatic let_block_settle();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [LIMIT_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_HEADER_PAGES) begin
         header_count = value[PAGE_W-1:0];
         recount_free_pages();
      end else begin
         cache_limit = value;
      end
      @(posedge clock);
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // ---------------------------------------------------------------- checking

   function automatic void flag_mismatch(string why, page_result_type e,
                                         page_result_type g);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch, %s:", why);
         $display("  expected kind %0d status %0d page %0d count %0d already %0d last %0d",
                  e.kind, e.status, e.page, e.count, e.already, e.last);
         $display("  got      kind %0d status %0d page %0d count %0d already %0d last %0d",
                  g.kind, g.status, g.page, g.count, g.already, g.last);
      end
   endfunction

   always @(posedge clock) begin : check_results
      page_result_type got;
      page_result_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind    = kind_type'(rsp_kind);
         got.status  = status_type'(rsp_status);
         got.page    = rsp_page;
         got.count   = rsp_count;
         got.already = rsp_already_committed;
         got.last    = rsp_last;
         if (awaited_results.size() == 0) begin
            flag_mismatch("result beat with nothing owed", '0, got);
         end else begin
            owed = awaited_results.pop_front();
            if (got !== owed)
               flag_mismatch("wrong field", owed, got);
         end
      end
   end

   // hang guard: any accepted beat on either side counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // size errors, filling the segment, bad frees, fragmentation, cache overflow
   task automatic test_directed_runs();
      send_beat(ACT_ALLOC, 0, 0, 1'b0);        // zero size
      send_beat(ACT_ALLOC, MAX_RUN + 1, 127, 1'b0);
      send_beat(ACT_ALLOC, 128, 85, 1'b0);     // top bit of the count set
      send_beat(ACT_ALLOC, 1, 0, 1'b0);
      send_beat(ACT_ALLOC, MAX_RUN, 42, 1'b0);
      send_beat(ACT_ALLOC, 31, 0, 1'b0);
      send_beat(ACT_ALLOC, 31, 0, 1'b0);       // segment now full
      send_beat(ACT_ALLOC, 1, 0, 1'b0);        // too few free pages
      send_beat(ACT_FREE, 128, 0, 1'b0);       // no run starts under the header
      send_beat(ACT_FREE, 0, 5, 1'b0);         // middle of a run
      send_beat(ACT_FREE, 255, 1, 1'b1);       // kept backed, sender waits first
      send_beat(ACT_FREE, 7, 66, 1'b0);
      send_beat(ACT_ALLOC, 32, 0, 1'b0);       // enough pages, no stretch long enough
      send_beat(ACT_FREE, 0, 97, 1'b0);
      send_beat(ACT_FREE, 0, 2, 1'b0);         // cache would overflow, so decommit
      send_beat(ACT_ALLOC, 40, 0, 1'b0);       // part backed, part newly committed
   endtask

   // header moves down to zero and up to all but the last page, cache limit at zero
   task automatic test_header_change();
      let_block_settle();
      write_reg(CSR_CACHE_LIMIT, '0);
      write_reg(CSR_HEADER_PAGES, 16'hFF80);   // header zero, junk above the field
      send_beat(ACT_ALLOC, 1, 0, 1'b0);        // page zero is usable now
      send_beat(ACT_ALLOC, 3, 127, 1'b0);
      let_block_settle();
      write_reg(CSR_HEADER_PAGES, 16'h5A7F);   // all but the last page reserved
      send_beat(ACT_ALLOC, 2, 0, 1'b0);
      send_beat(ACT_FREE, 0, 0, 1'b0);         // freed run lies under the header
      send_beat(ACT_ALLOC, 1, 0, 1'b0);
      let_block_settle();
      write_reg(CSR_HEADER_PAGES, 16'h0001);
      write_reg(CSR_CACHE_LIMIT, 16'hFFFF);
   endtask

   // mostly live allocate/free traffic, some bad sizes and stray frees
   task automatic test_random_mix(int items);
      int n;
      int p;
      int pick;
      int want;
      int live[$];
      bit hold;
      for (n = 0; n < items; n++) begin
         live = {};
         for (p = 0; p < SEGMENT_PAGES; p++)
            if (run_len[p] != 0)
               live.push_back(p);
         hold = ($urandom_range(19) == 0);
         pick = $urandom_range(99);
         if (live.size() != 0 && pick < 45) begin
            send_beat(ACT_FREE, $urandom_range(128),
                      live[$urandom_range(live.size() - 1)], hold);
         end else if (pick < 50) begin
            send_beat(ACT_FREE, $urandom_range(128), $urandom_range(127), hold);
         end else begin
            case ($urandom_range(15))
               0:       want = $urandom_range(1) ? 0 : $urandom_range(128, MAX_RUN + 1);
               1, 2, 3: want = $urandom_range(MAX_RUN, 9);
               default: want = $urandom_range(8, 1);
            endcase
            send_beat(ACT_ALLOC, want, $urandom_range(127), hold);
         end
      end
   endtask

   initial begin
      reset_segment();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      test_directed_runs();
      test_header_change();
      test_random_mix(40);

      // the other way round, with a mid-sized header and a roomier cache
      let_block_settle();
      send_idle_pct = 79;
      recv_idle_pct = 36;
      write_reg(CSR_HEADER_PAGES, 16'd8);
      write_reg(CSR_CACHE_LIMIT, 16'd200);
      test_random_mix(35);

      // nearly everything reserved and nothing cached
      let_block_settle();
      write_reg(CSR_HEADER_PAGES, 16'd127);
      write_reg(CSR_CACHE_LIMIT, 16'd0);
      test_random_mix(10);

      // no idling on either side
      let_block_settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_HEADER_PAGES, 16'd3);
      write_reg(CSR_CACHE_LIMIT, 16'd24);
      test_random_mix(25);

      let_block_settle();
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
